// File: hdl/mte_pkg.sv
// shared types, codes and default sizes for the multiset table engine
`timescale 1ns / 1ps

package mte_pkg;

	localparam int DISTINCT_DEPTH_DEF   = 16;
	localparam int OCCURRENCE_DEPTH_DEF = 64;
	localparam int VALUE_W              = 32;
	localparam int REQ_W                = 2;
	localparam int STATUS_W             = 2;
	localparam int OUT_CNT_W            = 7;

	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DSCAN,
		FSM_OSCAN,
		FSM_COMMIT
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic dscan;
		logic oscan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic dscan_done;
		logic found;
		logic oscan_done;
	} sts_t;

endpackage

// File: hdl/mte_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/mte_ctrl.sv
// sequencing state machine for the multiset table engine
`timescale 1ns / 1ps

module mte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mte_pkg::sts_t sts,
	output mte_pkg::cmd_t cmd
);

	mte_pkg::fsm_state_t state_q;
	mte_pkg::fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mte_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			mte_pkg::FSM_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = mte_pkg::FSM_DSCAN;
				end
			end
			mte_pkg::FSM_DSCAN: begin
				cmd.dscan = 1'b1;
				if (sts.dscan_done) begin
					// an absent value has no occurrences to walk
					state_d = sts.found ? mte_pkg::FSM_OSCAN : mte_pkg::FSM_COMMIT;
				end
			end
			mte_pkg::FSM_OSCAN: begin
				cmd.oscan = 1'b1;
				if (sts.oscan_done) begin
					state_d = mte_pkg::FSM_COMMIT;
				end
			end
			mte_pkg::FSM_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = mte_pkg::FSM_IDLE;
			end
			default: begin
				state_d = mte_pkg::FSM_IDLE;
			end
		endcase
	end

	assign busy = (state_q != mte_pkg::FSM_IDLE);

endmodule

// File: hdl/mte_dp.sv
// datapath: distinct table, occurrence list, scan counters and result registers
`timescale 1ns / 1ps

module mte_dp #(
	parameter int DISTINCT_DEPTH   = mte_pkg::DISTINCT_DEPTH_DEF,
	parameter int OCCURRENCE_DEPTH = mte_pkg::OCCURRENCE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mte_pkg::cmd_t                  cmd,
	output mte_pkg::sts_t                  sts,
	input  logic [mte_pkg::REQ_W-1:0]      req_type,
	input  logic signed [mte_pkg::VALUE_W-1:0] value,
	output logic                           done,
	output logic [mte_pkg::STATUS_W-1:0]   status,
	output logic                           present,
	output logic [mte_pkg::OUT_CNT_W-1:0]  occurrences,
	output logic [mte_pkg::OUT_CNT_W-1:0]  total_size,
	output logic                           is_empty
);

	localparam int AW_D  = $clog2(DISTINCT_DEPTH);
	localparam int CW_D  = $clog2(DISTINCT_DEPTH + 1);
	localparam int AW_O  = $clog2(OCCURRENCE_DEPTH);
	localparam int CW_O  = $clog2(OCCURRENCE_DEPTH + 1);
	localparam int OUT_W = mte_pkg::OUT_CNT_W;
	localparam logic [CW_D-1:0] DD_C = CW_D'(DISTINCT_DEPTH);
	localparam logic [CW_O-1:0] OD_C = CW_O'(OCCURRENCE_DEPTH);

	// captured request
	logic [mte_pkg::REQ_W-1:0]   req_q;
	logic [mte_pkg::VALUE_W-1:0] value_q;

	// bag state
	logic [CW_D-1:0] dused_q;
	logic [CW_O-1:0] oused_q;

	// distinct table scan
	logic [CW_D-1:0]             d_iss_q;
	logic                        d_vld_s1;
	logic [AW_D-1:0]             d_idx_s1;
	logic [mte_pkg::VALUE_W-1:0] d_rdata;
	logic                        found_q;
	logic [AW_D-1:0]             slot_q;
	logic                        d_issue;
	logic                        d_hit;

	// occurrence list scan
	logic [CW_O-1:0] o_iss_q;
	logic            o_vld_s1;
	logic [AW_O-1:0] o_idx_s1;
	logic [AW_D-1:0] o_rdata;
	logic            removed_q;
	logic [CW_O-1:0] cnt_q;
	logic            o_issue;
	logic            o_hit;
	logic            o_take;
	logic            o_shift;

	// commit
	logic                          add_req;
	logic                          rem_req;
	logic                          add_ok;
	logic                          new_ins;
	logic [CW_O-1:0]               oused_nx;
	logic [CW_O-1:0]               cnt_nx;
	logic [mte_pkg::STATUS_W-1:0]  status_nx;
	logic [CW_O+OUT_W-1:0]         cnt_ext;
	logic [CW_O+OUT_W-1:0]         oused_ext;

	// ram ports
	logic            d_we;
	logic            o_we;
	logic [AW_O-1:0] o_waddr;
	logic [AW_D-1:0] o_wdata;

	// result registers
	logic                         done_q;
	logic [mte_pkg::STATUS_W-1:0] status_q;
	logic                         present_q;
	logic [OUT_W-1:0]             occ_q;
	logic [OUT_W-1:0]             total_q;
	logic                         empty_q;

	// slot as a count-width value for checks
	logic [CW_D:0] slot_ext;

	assign d_hit   = d_vld_s1 && (d_rdata == value_q);
	assign d_issue = cmd.dscan && !found_q && !d_hit && (d_iss_q < dused_q);

	assign o_issue = cmd.oscan && (o_iss_q < oused_q);
	assign o_hit   = o_vld_s1 && (o_rdata == slot_q);
	assign o_take  = o_hit && !removed_q && (req_q == mte_pkg::REQ_REMOVE);
	// entries after the removed one move down by one
	assign o_shift = cmd.oscan && o_vld_s1 && removed_q;

	assign add_req = (req_q == mte_pkg::REQ_ADD);
	assign rem_req = (req_q == mte_pkg::REQ_REMOVE);
	assign add_ok  = add_req && (oused_q < OD_C) && (found_q || (dused_q < DD_C));
	assign new_ins = add_ok && !found_q;

	always_comb begin
		oused_nx  = oused_q;
		cnt_nx    = cnt_q;
		status_nx = mte_pkg::STS_OK;
		if (add_ok) begin
			oused_nx = oused_q + CW_O'(1);
			cnt_nx   = cnt_q + CW_O'(1);
		end else if (rem_req && removed_q) begin
			oused_nx = oused_q - CW_O'(1);
			cnt_nx   = cnt_q - CW_O'(1);
		end
		if (add_req && !add_ok) begin
			status_nx = mte_pkg::STS_FULL;
		end else if (rem_req && !removed_q) begin
			status_nx = mte_pkg::STS_NOT_FOUND;
		end
	end

	assign cnt_ext   = {{OUT_W{1'b0}}, cnt_nx};
	assign oused_ext = {{OUT_W{1'b0}}, oused_nx};

	assign d_we    = cmd.commit && new_ins;
	assign o_we    = o_shift || (cmd.commit && add_ok);
	assign o_waddr = o_shift ? (o_idx_s1 - AW_O'(1)) : oused_q[AW_O-1:0];
	assign o_wdata = o_shift ? o_rdata : (found_q ? slot_q : dused_q[AW_D-1:0]);

	mte_ram #(
		.WIDTH (mte_pkg::VALUE_W),
		.DEPTH (DISTINCT_DEPTH)
	) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (dused_q[AW_D-1:0]),
		.wdata (value_q),
		.raddr (d_iss_q[AW_D-1:0]),
		.rdata (d_rdata)
	);

	mte_ram #(
		.WIDTH (AW_D),
		.DEPTH (OCCURRENCE_DEPTH)
	) u_occ_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_iss_q[AW_O-1:0]),
		.rdata (o_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dused_q   <= '0;
			oused_q   <= '0;
			d_iss_q   <= '0;
			d_vld_s1  <= 1'b0;
			found_q   <= 1'b0;
			o_iss_q   <= '0;
			o_vld_s1  <= 1'b0;
			removed_q <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.load) begin
				d_iss_q   <= '0;
				d_vld_s1  <= 1'b0;
				found_q   <= 1'b0;
				o_iss_q   <= '0;
				o_vld_s1  <= 1'b0;
				removed_q <= 1'b0;
				cnt_q     <= '0;
			end else begin
				d_vld_s1 <= d_issue;
				if (d_issue) begin
					d_iss_q <= d_iss_q + CW_D'(1);
				end
				if (d_hit) begin
					found_q <= 1'b1;
				end
				o_vld_s1 <= o_issue;
				if (o_issue) begin
					o_iss_q <= o_iss_q + CW_O'(1);
				end
				if (o_take) begin
					removed_q <= 1'b1;
				end
				if (o_hit) begin
					cnt_q <= cnt_q + CW_O'(1);
				end
			end
			if (cmd.commit) begin
				oused_q <= oused_nx;
				if (new_ins) begin
					dused_q <= dused_q + CW_D'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			value_q <= value;
		end
		d_idx_s1 <= d_iss_q[AW_D-1:0];
		o_idx_s1 <= o_iss_q[AW_O-1:0];
		if (d_hit) begin
			slot_q <= d_idx_s1;
		end
		if (cmd.commit) begin
			status_q  <= status_nx;
			present_q <= (cnt_nx != '0);
			occ_q     <= cnt_ext[OUT_W-1:0];
			total_q   <= oused_ext[OUT_W-1:0];
			empty_q   <= (oused_nx == '0);
		end
	end

	assign sts.dscan_done = found_q || (!d_vld_s1 && (d_iss_q == dused_q));
	assign sts.found      = found_q;
	assign sts.oscan_done = !o_vld_s1 && (o_iss_q == oused_q);

	assign done        = done_q;
	assign status      = status_q;
	assign present     = present_q;
	assign occurrences = occ_q;
	assign total_size  = total_q;
	assign is_empty    = empty_q;

	assign slot_ext = {1'b0, {(CW_D - AW_D){1'b0}}, slot_q};

	a_dused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dused_q <= DD_C)
		else $error("distinct count beyond table depth");

	a_oused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oused_q <= OD_C)
		else $error("occurrence count beyond list depth");

	a_slot_used: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (slot_ext < {1'b0, dused_q}))
		else $error("matched slot lies outside the used table");

	a_removed_found: assert property (@(posedge clk) disable iff (!arst_n)
		removed_q |-> (found_q && (cnt_q != '0)))
		else $error("occurrence removed without a counted match");

	a_commit_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (oused_q == $past(oused_q) + CW_O'(1)
			|| oused_q == $past(oused_q) - CW_O'(1)
			|| oused_q == $past(oused_q)))
		else $error("bag size moved by more than one");

endmodule

// File: hdl/multiset_table_engine.sv
// top level of the multiset table engine
`timescale 1ns / 1ps

// multiset of signed 32-bit values with add, remove-one and query requests.
// input: a beat is taken on a rising edge with start high and busy low;
// req_type and value are sampled there. busy stays high until the result
// has been produced, so one request is in flight at a time.
// output: done is high for exactly one cycle with status, present,
// occurrences, total_size and is_empty valid in that cycle; the receiver
// cannot stall, and a new request may be started in the same cycle.
// sequence: a distinct-table scan, then, when the value is in the table, an
// occurrence walk (count, plus the close-up shift on remove), then a commit
// state; done is registered from the commit state. each scan reads one entry
// at a time through the single read port of its table ram. a new request is
// taken only once the previous one has been committed.
// reset: asynchronous, clears the used counts so the bag comes up empty;
// table contents are not cleared and need no clearing pass.

module multiset_table_engine #(
	parameter int DISTINCT_DEPTH   = mte_pkg::DISTINCT_DEPTH_DEF,
	parameter int OCCURRENCE_DEPTH = mte_pkg::OCCURRENCE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [mte_pkg::REQ_W-1:0]          req_type,
	input  logic signed [mte_pkg::VALUE_W-1:0] value,
	output logic                               done,
	output logic [mte_pkg::STATUS_W-1:0]       status,
	output logic                               present,
	output logic [mte_pkg::OUT_CNT_W-1:0]      occurrences,
	output logic [mte_pkg::OUT_CNT_W-1:0]      total_size,
	output logic                               is_empty
);

	mte_pkg::cmd_t cmd;
	mte_pkg::sts_t sts;

	mte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	mte_dp #(
		.DISTINCT_DEPTH   (DISTINCT_DEPTH),
		.OCCURRENCE_DEPTH (OCCURRENCE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.value       (value),
		.done        (done),
		.status      (status),
		.present     (present),
		.occurrences (occurrences),
		.total_size  (total_size),
		.is_empty    (is_empty)
	);

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the multiset table engine
`timescale 1ns / 1ps

module tb_top;

	localparam int DIST_DEPTH = mte_pkg::DISTINCT_DEPTH_DEF;
	localparam int OCC_DEPTH = mte_pkg::OCCURRENCE_DEPTH_DEF;
	localparam int REQ_W = mte_pkg::REQ_W;
	localparam int VALUE_W = mte_pkg::VALUE_W;
	localparam int STATUS_W = mte_pkg::STATUS_W;
	localparam int OUT_CNT_W = mte_pkg::OUT_CNT_W;
	// unused request code, the block handles it as a query
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = DIST_DEPTH + OCC_DEPTH + 20;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		logic [REQ_W-1:0]   req;
		logic [VALUE_W-1:0] val;
	} bag_req_t;

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic                 present;
		logic [OUT_CNT_W-1:0] occurrences;
		logic [OUT_CNT_W-1:0] total;
		logic                 empty;
	} bag_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [REQ_W-1:0]           req_type = mte_pkg::REQ_QUERY;
	logic [VALUE_W-1:0]         value = '0;
	logic                       busy;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic                       present;
	logic [OUT_CNT_W-1:0]       occurrences;
	logic [OUT_CNT_W-1:0]       total_size;
	logic                       is_empty;

	bag_req_t    pending_reqs[$];
	bag_result_t expected_results[$];
	int          idle_pct = 0;
	int          n_errors = 0;
	int          n_accepted = 0;
	int          n_checked = 0;
	int          n_full = 0;
	int          n_not_found = 0;
	int          n_at_capacity = 0;

	// predictor state: distinct table and ordered occurrence list
	logic [VALUE_W-1:0] bag_vals[DIST_DEPTH];
	int                 bag_vals_used = 0;
	int                 bag_slots[OCC_DEPTH];
	int                 bag_slots_used = 0;

	multiset_table_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.status(status),
		.present(present),
		.occurrences(occurrences),
		.total_size(total_size),
		.is_empty(is_empty)
	);

	always #5 clk = ~clk;

	function automatic bag_result_t predict_bag(logic [REQ_W-1:0] req,
			logic [VALUE_W-1:0] val);
		bag_result_t r;
		int slot;
		int hits;
		int i;
		int j;
		slot = bag_vals_used;
		for (i = 0; i < bag_vals_used; i++) begin
			if (bag_vals[i] == val) begin
				slot = i;
				break;
			end
		end
		r.status = mte_pkg::STS_OK;
		case (req)
			mte_pkg::REQ_ADD: begin
				if (bag_slots_used >= OCC_DEPTH ||
						(slot == bag_vals_used && bag_vals_used >= DIST_DEPTH)) begin
					r.status = mte_pkg::STS_FULL;
				end else begin
					if (slot == bag_vals_used) begin
						bag_vals[slot] = val;
						bag_vals_used++;
					end
					bag_slots[bag_slots_used] = slot;
					bag_slots_used++;
				end
			end
			mte_pkg::REQ_REMOVE: begin
				r.status = mte_pkg::STS_NOT_FOUND;
				if (slot < bag_vals_used) begin
					// drop the earliest occurrence and close up the list
					for (i = 0; i < bag_slots_used; i++) begin
						if (bag_slots[i] == slot) begin
							for (j = i; j < bag_slots_used - 1; j++)
								bag_slots[j] = bag_slots[j + 1];
							bag_slots_used--;
							r.status = mte_pkg::STS_OK;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		hits = 0;
		if (slot < bag_vals_used) begin
			for (i = 0; i < bag_slots_used; i++)
				if (bag_slots[i] == slot)
					hits++;
		end
		r.present = (hits > 0);
		r.occurrences = hits[OUT_CNT_W-1:0];
		r.total = bag_slots_used[OUT_CNT_W-1:0];
		r.empty = (bag_slots_used == 0);
		return r;
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
		bag_req_t b;
		b.req = req;
		b.val = val;
		pending_reqs.push_back(b);
	endtask

	task automatic check_field(input string field, input logic [OUT_CNT_W-1:0] exp,
			input logic [OUT_CNT_W-1:0] act);
		if (exp !== act) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
		end
	endtask

	// driver: a beat is taken when start is high and busy low
	always @(posedge clk or negedge arst_n) begin
		bag_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= mte_pkg::REQ_QUERY;
			value <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_bag(req_type, value));
				n_accepted++;
			end
			if (!(start && busy)) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					nxt = pending_reqs.pop_front();
					start <= 1'b1;
					req_type <= nxt.req;
					value <= nxt.val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: one result per done strobe, no back-pressure possible
	always @(posedge clk) begin
		bag_result_t exp;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				n_errors++;
				$display("%0t: result with nothing expected, status %0d total_size %0d",
					$time, status, total_size);
			end else begin
				exp = expected_results.pop_front();
				n_checked++;
				check_field("status", OUT_CNT_W'(exp.status), OUT_CNT_W'(status));
				check_field("present", OUT_CNT_W'(exp.present), OUT_CNT_W'(present));
				check_field("occurrences", exp.occurrences, occurrences);
				check_field("total_size", exp.total, total_size);
				check_field("is_empty", OUT_CNT_W'(exp.empty), OUT_CNT_W'(is_empty));
				if (exp.status == mte_pkg::STS_FULL)
					n_full++;
				if (exp.status == mte_pkg::STS_NOT_FOUND)
					n_not_found++;
				if (exp.total == OCC_DEPTH)
					n_at_capacity++;
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] known_vals[DIST_DEPTH];
		logic [VALUE_W-1:0] v;
		logic [REQ_W-1:0]   rq;
		int                 phase_idle[4];
		bit                 filling;
		bit                 dup;
		int                 burst_left;
		int                 ph;
		int                 k;
		int                 m;
		int                 r;

		known_vals[0] = 32'h8000_0000;
		known_vals[1] = 32'h7fff_ffff;
		known_vals[2] = 32'hffff_ffff;
		known_vals[3] = 32'h0000_0000;
		for (k = 4; k < DIST_DEPTH; k++) begin
			do begin
				v = $urandom;
				dup = 1'b0;
				for (m = 0; m < k; m++)
					if (known_vals[m] == v)
						dup = 1'b1;
			end while (dup);
			known_vals[k] = v;
		end

		// directed: extremes, repeats, removes of absent values, spare code, table full
		for (k = 0; k < 4; k++)
			queue_req(mte_pkg::REQ_ADD, known_vals[k]);
		queue_req(mte_pkg::REQ_ADD, known_vals[3]);
		queue_req(mte_pkg::REQ_QUERY, known_vals[3]);
		queue_req(REQ_SPARE, known_vals[1]);
		queue_req(mte_pkg::REQ_QUERY, 32'h0000_1234);
		queue_req(mte_pkg::REQ_REMOVE, known_vals[3]);
		queue_req(mte_pkg::REQ_REMOVE, known_vals[2]);
		// still in the table but no occurrence left
		queue_req(mte_pkg::REQ_REMOVE, known_vals[2]);
		queue_req(mte_pkg::REQ_REMOVE, 32'h5a5a_5a5a);
		for (k = 4; k < DIST_DEPTH; k++)
			queue_req(mte_pkg::REQ_ADD, known_vals[k]);
		// distinct table now full
		queue_req(mte_pkg::REQ_ADD, 32'h0bad_f00d);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		phase_idle[0] = 0;
		phase_idle[1] = 81;
		phase_idle[2] = 14;
		phase_idle[3] = 0;
		filling = 1'b1;
		burst_left = $urandom_range(90, 140);
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			// bursts alternate between filling the bag to capacity and draining it
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (burst_left == 0) begin
					filling = !filling;
					burst_left = $urandom_range(90, 140);
				end
				burst_left--;
				r = $urandom_range(0, 99);
				if (r < 85)
					rq = filling ? mte_pkg::REQ_ADD : mte_pkg::REQ_REMOVE;
				else if (r < 90)
					rq = filling ? mte_pkg::REQ_REMOVE : mte_pkg::REQ_ADD;
				else if (r < 97)
					rq = mte_pkg::REQ_QUERY;
				else
					rq = REQ_SPARE;
				if ($urandom_range(0, 99) < 12)
					v = $urandom;
				else
					v = known_vals[$urandom_range(0, DIST_DEPTH - 1)];
				queue_req(rq, v);
			end
			while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d requests and %0d checked results over four sender phases",
			n_accepted, n_checked);
		$display("full %0d times, not found %0d times, bag at capacity in %0d results",
			n_full, n_not_found, n_at_capacity);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("** multiset_table_engine: PASSED **");
		end else begin
			$display("** multiset_table_engine: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still expected", expected_results.size());
		$display("** multiset_table_engine: FAILED **");
		$finish;
	end

endmodule
